### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the CRC stream block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, skipped while reset is high.
`define CRC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("CRC stream assertion failed");

// Checked at every rising clock edge, reset included.
`define CRC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("CRC stream assertion failed");

`endif

### sv/crc32s_pkg.sv
// ---------------------------------------------------------------------------
// crc32s_pkg
// Types, constants and the byte table function of the CRC-32 stream block.
// ---------------------------------------------------------------------------
package crc32s_pkg;

   localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
   localparam logic [31:0] PolyReset   = 32'h04C1_1DB7;
   localparam logic [2:0]  PrefixBytes = 3'd4;

   typedef struct packed {
      logic        valid;
      logic [31:0] checksum;
   } result_type;

   // Remainder of top<<24 after eight MSB-first division steps.
   function automatic logic [31:0] table_entry(input logic [7:0]  top,
                                               input logic [31:0] poly);
      logic [31:0] acc;
      acc = {top, 24'h00_0000};
      for (int k = 0; k < 8; k++) begin
         if (acc[31]) begin
            acc = {acc[30:0], 1'b0} ^ poly;
         end else begin
            acc = {acc[30:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

### sv/crc32s_req_if.sv
// ---------------------------------------------------------------------------
// crc32s_req_if
// Request channel: one message byte and its end-of-message flag.
// ---------------------------------------------------------------------------
interface crc32s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### sv/crc32s_rsp_if.sv
// ---------------------------------------------------------------------------
// crc32s_rsp_if
// Response channel: the checksum of one finished message.
// ---------------------------------------------------------------------------
interface crc32s_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] checksum;

   modport source (output valid, output checksum, input ready);
   modport sink   (input valid, input checksum, output ready);
endinterface

### sv/crc32_msb_first_stream.sv
// ---------------------------------------------------------------------------
// crc32_msb_first_stream
// Augmented-form MSB-first CRC-32 over a byte stream with a programmable
// polynomial; one checksum per message, given with its last byte.
// ---------------------------------------------------------------------------
//   Port      Dir    Carries
//   req_bus   in     data_byte[7:0], last_byte      (valid/ready)
//   rsp_bus   out    checksum[31:0]                 (valid/ready)
//   csr_*     in     polynomial write, csr_wr_en + csr_wr_data[31:0]
//
// One byte is taken per cycle; only a last byte waits in the input
// register, and only while a previous checksum is still unread. The table
// lookup and XOR of a byte sit between the input register and the
// CRC/result registers. A checksum is valid on rsp_bus once its last byte
// has left the input register and the result register holds the checksum.
// Reset clears the CRC to all ones, the byte count to zero and restores
// the default polynomial 0x04C11DB7.
// ---------------------------------------------------------------------------
module crc32_msb_first_stream (
   input  logic        clock,
   input  logic        reset,
   crc32s_req_if.sink  req_bus,
   crc32s_rsp_if.source rsp_bus,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0]            poly;
   logic                   out_free;
   crc32s_pkg::result_type result;

   crc32s_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .poly        (poly)
   );

   crc32s_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .poly     (poly),
      .out_free (out_free),
      .result   (result)
   );

   crc32s_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

endmodule

### sv/crc32s_csr.sv
// ---------------------------------------------------------------------------
// crc32s_csr
// Polynomial register, written through the configuration port.
// ---------------------------------------------------------------------------
module crc32s_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output logic [31:0] poly
);

   logic [31:0] poly_ff;
   logic [31:0] poly_in;

   always_comb begin
      poly_in = csr_wr_en ? csr_wr_data : poly_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= crc32s_pkg::PolyReset;
      end else begin
         poly_ff <= poly_in;
      end
   end

   assign poly = poly_ff;

endmodule

### sv/crc32s_engine.sv
// ---------------------------------------------------------------------------
// crc32s_engine
// Input, CRC and count registers; one byte per cycle unless a last byte waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module crc32s_engine (
   input  logic                   clock,
   input  logic                   reset,
   crc32s_req_if.sink             req_bus,
   input  logic [31:0]            poly,
   input  logic                   out_free,
   output crc32s_pkg::result_type result
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic [31:0] crc_upd;
   logic [2:0]  count_upd;
   logic        accept;
   logic        advance;

   // A final byte waits in the input register until the result slot is free.
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept      = req_bus.valid && req_bus.ready;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   // The first four bytes of a message are stored complemented, top slot first.
   always_comb begin
      if (count_ff[2]) begin
         crc_upd = {crc_ff[23:0], in_byte_ff}
                   ^ crc32s_pkg::table_entry(crc_ff[31:24], poly);
      end else begin
         case (count_ff[1:0])
            2'd0:    crc_upd = {~in_byte_ff, crc_ff[23:0]};
            2'd1:    crc_upd = {crc_ff[31:24], ~in_byte_ff, crc_ff[15:0]};
            2'd2:    crc_upd = {crc_ff[31:16], ~in_byte_ff, crc_ff[7:0]};
            2'd3:    crc_upd = {crc_ff[31:8], ~in_byte_ff};
            default: crc_upd = crc_ff;
         endcase
      end
      count_upd = count_ff[2] ? count_ff : count_ff + 3'd1;
   end

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      if (advance) begin
         if (in_last_ff) begin
            crc_in   = crc32s_pkg::CrcInit;
            count_in = 3'd0;
         end else begin
            crc_in   = crc_upd;
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= crc32s_pkg::CrcInit;
         count_ff <= 3'd0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      result.valid    = advance && in_last_ff;
      result.checksum = ~crc_upd;
   end

   `CRC_ASSERT(a_restart_after_last, clock, reset, (advance && in_last_ff) |=> (crc_ff == crc32s_pkg::CrcInit && count_ff == 3'd0))
   `CRC_ASSERT(a_prefix_count, clock, reset, (advance && !in_last_ff && count_ff < crc32s_pkg::PrefixBytes) |=> (count_ff == $past(count_ff) + 3'd1))
   `CRC_ASSERT(a_result_has_room, clock, reset, result.valid |-> out_free)

endmodule

### sv/crc32s_out_reg.sv
// ---------------------------------------------------------------------------
// crc32s_out_reg
// Result register that holds a checksum until the response is taken.
// ---------------------------------------------------------------------------
module crc32s_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  crc32s_pkg::result_type result,
   output logic                   out_free,
   crc32s_rsp_if.source           rsp_bus
);

   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] checksum_ff;

   assign out_free = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      if (result.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         checksum_ff <= result.checksum;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.checksum = checksum_ff;

endmodule
